[sv/dcrc_pkg.sv]
// Shared constants, types and helper functions of the DMA channel register controller.
// No dependencies.
`default_nettype none

package dcrc_pkg;

   localparam int NUM_CHANNELS = 7;
   localparam int CHAN_W       = 3;
   localparam int DATA_W       = 32;
   localparam int ADDR_W       = 24;
   localparam int SIZE_W       = 17;

   localparam logic [CHAN_W-1:0] COMMON_SEL = 3'd7;

   // common register select
   localparam logic [1:0] REG_PRIO = 2'd0;
   localparam logic [1:0] REG_IRQ  = 2'd1;
   localparam logic [1:0] REG_ID0  = 2'd2;
   localparam logic [1:0] REG_ID1  = 2'd3;

   // channel register select
   localparam logic [1:0] REG_BASE  = 2'd0;
   localparam logic [1:0] REG_BLOCK = 2'd1;
   localparam logic [1:0] REG_CTRL  = 2'd2;
   localparam logic [1:0] REG_NONE  = 2'd3;

   localparam logic [31:0] IRQ_WR_MASK    = 32'h00ff803f;
   localparam logic [31:0] CTRL_WR_MASK   = 32'h71770703;
   localparam logic [31:0] ID0_VALUE      = 32'h7ffac68b;
   localparam logic [31:0] ID1_VALUE      = 32'h00fffff7;
   localparam logic [31:0] ADDR_WR_MASK   = 32'h00ffffff;
   localparam logic [23:0] LIST_ADDR_MASK = 24'h1ffffc;
   localparam logic [23:0] FULL_ADDR_MASK = 24'hffffff;
   localparam logic [16:0] SIZE_WRAP      = 17'h10000;

   localparam logic [31:0] PAT_SYNC0_TO_DEV = 32'h01000201;
   localparam logic [31:0] PAT_SYNC0_TO_MEM = 32'h01000200;
   localparam logic [31:0] PAT_LIST         = 32'h01000401;
   localparam logic [31:0] PAT_BURST_IN     = 32'h11000000;
   localparam logic [31:0] PAT_CLEAR        = 32'h11000002;

   localparam int BUSY_BIT   = 24;
   localparam int FORCE_BIT  = 15;
   localparam int MASTER_BIT = 23;

   typedef enum logic {
      MODE_READ,
      MODE_WRITE
   } access_mode_type;

   typedef enum logic {
      ITEM_DONE,
      ITEM_XFER
   } item_kind_type;

   typedef enum logic [2:0] {
      XT_NONE,
      XT_DEV_BLK,
      XT_MEM_BLK,
      XT_LIST,
      XT_DEV,
      XT_MEM,
      XT_CLEAR,
      XT_NO_START
   } xfer_kind_type;

   function automatic xfer_kind_type start_type(logic [CHAN_W-1:0] ch, logic [31:0] ctl);
      xfer_kind_type ty;
      ty = XT_NO_START;
      case (ch)
         3'd0: if (ctl == PAT_SYNC0_TO_DEV) ty = XT_NONE;
         3'd1: if (ctl == PAT_SYNC0_TO_MEM) ty = XT_NONE;
         3'd2: begin
            if (ctl == PAT_SYNC0_TO_MEM) ty = XT_DEV_BLK;
            else if (ctl == PAT_SYNC0_TO_DEV) ty = XT_MEM_BLK;
            else if (ctl == PAT_LIST) ty = XT_LIST;
         end
         3'd3: if (ctl == PAT_BURST_IN) ty = XT_DEV;
         3'd4: if (ctl == PAT_SYNC0_TO_DEV) ty = XT_MEM;
         3'd6: if (ctl == PAT_CLEAR) ty = XT_CLEAR;
         default: ty = XT_NO_START;
      endcase
      return ty;
   endfunction

   function automatic logic irq_active(logic [31:0] w);
      return w[FORCE_BIT] | (w[MASTER_BIT] & (|(w[22:16] & w[30:24])));
   endfunction

   function automatic logic [SIZE_W-1:0] size_of(logic [15:0] v);
      return (v == 16'h0) ? SIZE_WRAP : {1'b0, v};
   endfunction

endpackage

`default_nettype wire

[sv/dma_channel_register_controller_unit.sv]
// Register front end of the seven-channel DMA controller: register file, start scan, result stream.
// Depends on dcrc_pkg.
`default_nettype none

// One register access enters per transfer on req_; a read yields one completion transfer, a write
// yields one transfer command per enabled channel that holds a start pattern (channels 6 down to
// 0), then the completion. The result register issues one item per cycle while rsp_tready allows,
// so an access yields 1 + (started channels) items, at most 7; reads sustain one per cycle unless
// the result port stalls. An access passes through the input, job and result registers.
module dma_channel_register_controller_unit #(
   parameter int NUM_CHANNELS = dcrc_pkg::NUM_CHANNELS
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [39:0]  req_tdata,   // reg_offset[6:0], write_data[38:7], zero
   input  wire logic         req_tuser,   // mode
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [103:0]      rsp_tdata,   // read_data, irq_pulse, irq_level, xfer_channel,
                                          // xfer_type, xfer_address, xfer_block_size,
                                          // xfer_block_count, zero
   output logic              rsp_tuser,   // item_kind
   output logic              rsp_tlast    // last
);

   // input register
   logic                       in_valid_ff, in_valid_in;
   logic                       in_mode_ff, in_mode_in;
   logic [6:0]                 in_off_ff, in_off_in;
   logic [31:0]                in_data_ff, in_data_in;

   // register file
   logic [31:0]                prio_ff, prio_in;
   logic [31:0]                irq_ff, irq_in;
   logic [23:0]                base_ff [NUM_CHANNELS];
   logic [23:0]                base_in [NUM_CHANNELS];
   logic [31:0]                blk_ff [NUM_CHANNELS];
   logic [31:0]                blk_in [NUM_CHANNELS];
   logic [31:0]                ctl_ff [NUM_CHANNELS];
   logic [31:0]                ctl_in [NUM_CHANNELS];

   // job register
   logic                       job_valid_ff, job_valid_in;
   logic [NUM_CHANNELS-1:0]    pend_ff, pend_in;
   dcrc_pkg::xfer_kind_type    jtype_ff [NUM_CHANNELS];
   dcrc_pkg::xfer_kind_type    jtype_in [NUM_CHANNELS];
   logic [NUM_CHANNELS-1:0]    jlvl_ff, jlvl_in;
   logic [31:0]                jrdata_ff, jrdata_in;
   logic                       jrose_ff, jrose_in;
   logic                       jirq_ff, jirq_in;

   // result register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_kind_ff, rsp_kind_in;
   logic [31:0]                rsp_rdata_ff, rsp_rdata_in;
   logic                       rsp_pulse_ff, rsp_pulse_in;
   logic                       rsp_level_ff, rsp_level_in;
   logic [2:0]                 rsp_chan_ff, rsp_chan_in;
   logic [2:0]                 rsp_type_ff, rsp_type_in;
   logic [23:0]                rsp_addr_ff, rsp_addr_in;
   logic [16:0]                rsp_bsz_ff, rsp_bsz_in;
   logic [16:0]                rsp_bcnt_ff, rsp_bcnt_in;
   logic                       rsp_last_ff, rsp_last_in;

   logic                       out_free;
   logic                       has_pend;
   logic                       job_take;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign has_pend   = |pend_ff;
   assign job_take   = in_valid_ff && (!job_valid_ff || (out_free && !has_pend));
   assign req_tready = !in_valid_ff || job_take;

   always_comb begin
      logic [2:0]                 ch;
      logic [1:0]                 rg;
      logic                       is_wr;
      logic [31:0]                rdata;
      logic [31:0]                prio_w;
      logic [31:0]                irq_w;
      logic [31:0]                ctl_w [NUM_CHANNELS];
      logic [NUM_CHANNELS-1:0]    start;
      dcrc_pkg::xfer_kind_type    sty [NUM_CHANNELS];
      logic [NUM_CHANNELS-1:0]    hi_mask;
      logic [6:0]                 flags_fin;
      logic [31:0]                irq_fin;
      logic [2:0]                 sel;
      dcrc_pkg::xfer_kind_type    cty;
      logic [31:0]                cnt;

      ch    = in_off_ff[6:4];
      rg    = in_off_ff[3:2];
      is_wr = (in_mode_ff == dcrc_pkg::MODE_WRITE);

      in_valid_in = in_valid_ff;
      in_mode_in  = in_mode_ff;
      in_off_in   = in_off_ff;
      in_data_in  = in_data_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
         in_mode_in  = req_tuser;
         in_off_in   = req_tdata[6:0];
         in_data_in  = req_tdata[38:7];
      end else if (job_take) begin
         in_valid_in = 1'b0;
      end

      // register access
      rdata  = '0;
      prio_w = prio_ff;
      irq_w  = irq_ff;
      base_in = base_ff;
      blk_in  = blk_ff;
      ctl_w   = ctl_ff;
      if (!is_wr) begin
         if (ch == dcrc_pkg::COMMON_SEL) begin
            case (rg)
               dcrc_pkg::REG_PRIO: rdata = prio_ff;
               dcrc_pkg::REG_IRQ:  rdata = irq_ff;
               dcrc_pkg::REG_ID0:  rdata = dcrc_pkg::ID0_VALUE;
               default:            rdata = dcrc_pkg::ID1_VALUE;
            endcase
         end else begin
            case (rg)
               dcrc_pkg::REG_BASE:  rdata = {8'h0, base_ff[ch]};
               dcrc_pkg::REG_BLOCK: rdata = blk_ff[ch];
               dcrc_pkg::REG_CTRL:  rdata = ctl_ff[ch];
               default:             rdata = '0;
            endcase
         end
      end else begin
         if (ch == dcrc_pkg::COMMON_SEL) begin
            case (rg)
               dcrc_pkg::REG_PRIO: prio_w = in_data_ff;
               dcrc_pkg::REG_IRQ:  irq_w = {1'b0, irq_ff[30:24] & ~in_data_ff[30:24],
                                            in_data_ff[23:0] & dcrc_pkg::IRQ_WR_MASK[23:0]};
               default:            prio_w = prio_ff;
            endcase
         end else begin
            case (rg)
               dcrc_pkg::REG_BASE:  base_in[ch] = in_data_ff[23:0] &
                                                   dcrc_pkg::ADDR_WR_MASK[23:0];
               dcrc_pkg::REG_BLOCK: blk_in[ch] = in_data_ff;
               dcrc_pkg::REG_CTRL:  ctl_w[ch] = in_data_ff & dcrc_pkg::CTRL_WR_MASK;
               default:             ctl_w[ch] = ctl_ff[ch];
            endcase
         end
      end

      // start scan
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         sty[c]   = dcrc_pkg::start_type(c[2:0], ctl_w[c]);
         start[c] = is_wr && prio_w[4*c+3] && (sty[c] != dcrc_pkg::XT_NO_START);
      end
      flags_fin = irq_w[30:24] | (irq_w[22:16] & start);
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         hi_mask    = {NUM_CHANNELS{1'b1}} << c;
         jlvl_in[c] = dcrc_pkg::irq_active({1'b0, irq_w[30:24] | (irq_w[22:16] & start & hi_mask),
                                            irq_w[23:0]});
         ctl_in[c]  = start[c] ? (ctl_w[c] & ~(32'h1 << dcrc_pkg::BUSY_BIT)) : ctl_w[c];
      end
      irq_fin = {dcrc_pkg::irq_active({1'b0, flags_fin, irq_w[23:0]}), flags_fin, irq_w[23:0]};

      prio_in   = prio_w;
      irq_in    = irq_fin;
      jtype_in  = sty;
      pend_in   = start;
      jrdata_in = rdata;
      jrose_in  = is_wr && irq_fin[31] && !(irq_ff[31] && dcrc_pkg::irq_active(irq_w));
      jirq_in   = irq_fin[31];

      // emit from job
      sel = '0;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         if (pend_ff[c]) sel = c[2:0];
      end
      cty = jtype_ff[sel];
      cnt = blk_ff[sel];

      job_valid_in = job_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_rdata_in = rsp_rdata_ff;
      rsp_pulse_in = rsp_pulse_ff;
      rsp_level_in = rsp_level_ff;
      rsp_chan_in  = rsp_chan_ff;
      rsp_type_in  = rsp_type_ff;
      rsp_addr_in  = rsp_addr_ff;
      rsp_bsz_in   = rsp_bsz_ff;
      rsp_bcnt_in  = rsp_bcnt_ff;
      rsp_last_in  = rsp_last_ff;

      if (job_valid_ff && out_free) begin
         rsp_valid_in = 1'b1;
         if (has_pend) begin
            pend_in      = pend_ff & ~(NUM_CHANNELS'(1) << sel);
            rsp_kind_in  = dcrc_pkg::ITEM_XFER;
            rsp_rdata_in = '0;
            rsp_pulse_in = 1'b0;
            rsp_level_in = jlvl_ff[sel];
            rsp_chan_in  = sel;
            rsp_type_in  = 3'(cty);
            rsp_addr_in  = base_ff[sel] & ((cty == dcrc_pkg::XT_LIST) ?
                           dcrc_pkg::LIST_ADDR_MASK : dcrc_pkg::FULL_ADDR_MASK);
            rsp_last_in  = 1'b0;
            case (cty)
               dcrc_pkg::XT_DEV_BLK, dcrc_pkg::XT_MEM_BLK: begin
                  rsp_bsz_in  = dcrc_pkg::size_of(cnt[15:0]);
                  rsp_bcnt_in = dcrc_pkg::size_of(cnt[31:16]);
               end
               dcrc_pkg::XT_DEV, dcrc_pkg::XT_MEM, dcrc_pkg::XT_CLEAR: begin
                  rsp_bsz_in  = dcrc_pkg::size_of(cnt[15:0]);
                  rsp_bcnt_in = 17'd1;
               end
               default: begin
                  rsp_bsz_in  = 17'd1;
                  rsp_bcnt_in = 17'd1;
               end
            endcase
         end else begin
            job_valid_in = 1'b0;
            rsp_kind_in  = dcrc_pkg::ITEM_DONE;
            rsp_rdata_in = jrdata_ff;
            rsp_pulse_in = jrose_ff;
            rsp_level_in = jirq_ff;
            rsp_chan_in  = '0;
            rsp_type_in  = '0;
            rsp_addr_in  = '0;
            rsp_bsz_in   = '0;
            rsp_bcnt_in  = '0;
            rsp_last_in  = 1'b1;
         end
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      if (job_take) begin
         job_valid_in = 1'b1;
      end else begin
         pend_in   = (job_valid_ff && out_free && has_pend) ? pend_in : pend_ff;
         prio_in   = prio_ff;
         irq_in    = irq_ff;
         base_in   = base_ff;
         blk_in    = blk_ff;
         ctl_in    = ctl_ff;
         jtype_in  = jtype_ff;
         jlvl_in   = jlvl_ff;
         jrdata_in = jrdata_ff;
         jrose_in  = jrose_ff;
         jirq_in   = jirq_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         job_valid_ff <= 1'b0;
         pend_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         prio_ff      <= '0;
         irq_ff       <= '0;
         for (int c = 0; c < NUM_CHANNELS; c++) begin
            base_ff[c] <= '0;
            blk_ff[c]  <= '0;
            ctl_ff[c]  <= '0;
         end
      end else begin
         in_valid_ff  <= in_valid_in;
         job_valid_ff <= job_valid_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         prio_ff      <= prio_in;
         irq_ff       <= irq_in;
         base_ff      <= base_in;
         blk_ff       <= blk_in;
         ctl_ff       <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      in_mode_ff   <= in_mode_in;
      in_off_ff    <= in_off_in;
      in_data_ff   <= in_data_in;
      jtype_ff     <= jtype_in;
      jlvl_ff      <= jlvl_in;
      jrdata_ff    <= jrdata_in;
      jrose_ff     <= jrose_in;
      jirq_ff      <= jirq_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_rdata_ff <= rsp_rdata_in;
      rsp_pulse_ff <= rsp_pulse_in;
      rsp_level_ff <= rsp_level_in;
      rsp_chan_ff  <= rsp_chan_in;
      rsp_type_ff  <= rsp_type_in;
      rsp_addr_ff  <= rsp_addr_in;
      rsp_bsz_ff   <= rsp_bsz_in;
      rsp_bcnt_ff  <= rsp_bcnt_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {6'b0, rsp_bcnt_ff, rsp_bsz_ff, rsp_addr_ff, rsp_type_ff, rsp_chan_ff,
                        rsp_level_ff, rsp_pulse_ff, rsp_rdata_ff};

endmodule

`default_nettype wire

[sv/dcrc_checker.sv]
// Port-level checks of the DMA channel register controller result stream, bound to the top level.
// Depends on dcrc_pkg and dma_channel_register_controller_unit.
`default_nettype none

module dcrc_port_assertions (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         rsp_tvalid,
   input wire logic         rsp_tready,
   input wire logic [103:0] rsp_tdata,
   input wire logic         rsp_tuser,
   input wire logic         rsp_tlast
);

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
      $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result transfer changed");

   a_done_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser == dcrc_pkg::ITEM_DONE &&
      rsp_tdata[97:34] == 64'h0)
      else $error("completion carries command fields");

   a_xfer_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == dcrc_pkg::ITEM_XFER |-> !rsp_tlast &&
      rsp_tdata[32:0] == 33'h0 && rsp_tdata[36:34] != 3'd5 && rsp_tdata[36:34] != 3'd7 &&
      rsp_tdata[39:37] != 3'd7 && rsp_tdata[80:64] != 17'h0 && rsp_tdata[97:81] != 17'h0)
      else $error("malformed transfer command");

endmodule

bind dma_channel_register_controller_unit dcrc_port_assertions u_dcrc_port_assertions (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire
